>>> rtl/ksc_pkg.sv
// ----------------------------------------------------------------------------
// ksc_pkg: shared types and constants of the keyword substitution cipher
// Letter constants, the item format passed from the front end to the back end.
// ----------------------------------------------------------------------------
package ksc_pkg;

  localparam int unsigned Letters = 26;

  localparam logic [7:0] CharUpA   = 8'h41;  // 'A'
  localparam logic [7:0] CharUpZ   = 8'h5A;  // 'Z'
  localparam logic [7:0] CharLowA  = 8'h61;  // 'a'
  localparam logic [7:0] CharLowZ  = 8'h7A;  // 'z'
  localparam logic [7:0] CaseGap   = 8'd32;

  // Classified item as held in the queue between front and back end
  typedef struct packed {
    logic       text;    // 1: text byte, 0: key character
    logic       last;    // final key character
    logic       letter;  // data is a letter of either case
    logic       upper;   // data is an upper case letter
    logic [4:0] idx;     // letter index, A = 0
    logic [7:0] data;    // raw byte
  } ksc_item_t;

endpackage

>>> rtl/ksc_front.sv
// ----------------------------------------------------------------------------
// ksc_front: input classification and item queue
// Decodes each accepted item into letter/case/index and holds it in a short
// queue until the back end takes it.
// ----------------------------------------------------------------------------
module ksc_front import ksc_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  logic      command_i,
  input  logic [7:0] data_i,
  input  logic      last_key_i,
  output logic      head_valid_o,
  output ksc_item_t head_o,
  input  logic      head_pop_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  ksc_item_t            queue_q [QueueDepth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      count_q, count_d;
  ksc_item_t            item;
  logic                 is_upper;
  logic                 is_lower;
  logic [7:0]           folded;
  logic                 do_push;
  logic                 do_pop;

  always_comb begin
    is_upper    = (data_i >= CharUpA) && (data_i <= CharUpZ);
    is_lower    = (data_i >= CharLowA) && (data_i <= CharLowZ);
    folded      = is_lower ? (data_i - CaseGap) : data_i;
    item.text   = command_i;
    item.last   = last_key_i;
    item.letter = is_upper || is_lower;
    item.upper  = is_upper;
    item.idx    = 5'(folded - CharUpA);
    item.data   = data_i;
  end

  assign full         = (count_q == CntW'(QueueDepth));
  assign do_push      = push && !full;
  assign do_pop       = head_pop_i && (count_q != '0);
  assign head_valid_o = (count_q != '0);
  assign head_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      queue_q[wr_ptr_q] <= item;
    end
  end

endmodule

>>> rtl/ksc_back.sv
// ----------------------------------------------------------------------------
// ksc_back: key loading sequencer, substitution tables and result register
// Places key letters, completes the alphabet and builds the inverse table one
// entry per cycle, and substitutes text bytes into the result register.
// ----------------------------------------------------------------------------
module ksc_back import ksc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       direction_i,
  input  logic       head_valid_i,
  input  ksc_item_t  head_i,
  output logic       head_pop_o,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StFill = 2'd1;
  localparam logic [1:0] StInv  = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [4:0]         walk_q, walk_d;
  logic [4:0]         cipher_q [Letters];
  logic [4:0]         inverse_q [Letters];
  logic [Letters-1:0] used_q, used_d;
  logic [4:0]         cnt_q, cnt_d;
  logic               loading_q, loading_d;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         out_byte_q, out_byte_d;

  logic [Letters-1:0] used_eff;
  logic [4:0]         cnt_eff;
  logic [4:0]         cipher_raddr;
  logic [4:0]         cipher_rd;
  logic [4:0]         inverse_rd;
  logic [4:0]         text_sub;
  logic               c_we;
  logic [4:0]         c_waddr;
  logic [4:0]         c_wdata;
  logic               i_we;
  logic [4:0]         i_waddr;
  logic [4:0]         i_wdata;
  logic               out_free;

  assign cipher_raddr = (state_q == StInv) ? walk_q : head_i.idx;
  assign cipher_rd    = cipher_q[cipher_raddr];
  assign inverse_rd   = inverse_q[head_i.idx];
  assign text_sub     = direction_i ? inverse_rd : cipher_rd;
  assign out_free     = !out_valid_q || pop;
  assign used_eff     = loading_q ? used_q : '0;
  assign cnt_eff      = loading_q ? cnt_q : '0;

  always_comb begin
    state_d     = state_q;
    walk_d      = walk_q;
    used_d      = used_q;
    cnt_d       = cnt_q;
    loading_d   = loading_q;
    out_valid_d = out_valid_q && !pop;
    out_byte_d  = out_byte_q;
    head_pop_o  = 1'b0;
    c_we        = 1'b0;
    c_waddr     = cnt_eff;
    c_wdata     = head_i.idx;
    i_we        = 1'b0;
    i_waddr     = cipher_rd;
    i_wdata     = walk_q;
    unique case (state_q)
      StIdle: begin
        if (head_valid_i && !head_i.text) begin
          // a key character after a completed key starts a fresh key
          head_pop_o = 1'b1;
          loading_d  = 1'b1;
          used_d     = used_eff;
          cnt_d      = cnt_eff;
          if (head_i.letter && !used_eff[head_i.idx] && (cnt_eff < 5'(Letters))) begin
            c_we                 = 1'b1;
            used_d[head_i.idx]   = 1'b1;
            cnt_d                = cnt_eff + 1'b1;
          end
          if (head_i.last) begin
            state_d = StFill;
            walk_d  = 5'(Letters - 1);
          end
        end else if (head_valid_i && head_i.text && out_free) begin
          head_pop_o  = 1'b1;
          out_valid_d = 1'b1;
          if (head_i.letter) begin
            out_byte_d = {3'b000, text_sub} + (head_i.upper ? CharLowA : CharUpA);
          end else begin
            out_byte_d = head_i.data;
          end
        end
      end
      StFill: begin
        // append unused letters from Z down to A
        c_waddr = cnt_q;
        c_wdata = walk_q;
        if (!used_q[walk_q] && (cnt_q < 5'(Letters))) begin
          c_we           = 1'b1;
          used_d[walk_q] = 1'b1;
          cnt_d          = cnt_q + 1'b1;
        end
        if (walk_q == '0) begin
          state_d = StInv;
        end else begin
          walk_d = walk_q - 1'b1;
        end
      end
      StInv: begin
        i_we = 1'b1;
        if (walk_q == 5'(Letters - 1)) begin
          state_d   = StIdle;
          loading_d = 1'b0;
          walk_d    = '0;
        end else begin
          walk_d = walk_q + 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      walk_q      <= '0;
      used_q      <= '0;
      cnt_q       <= '0;
      loading_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < Letters; i++) begin
        cipher_q[i]  <= 5'(Letters - 1 - i);
        inverse_q[i] <= 5'(Letters - 1 - i);
      end
    end else begin
      state_q     <= state_d;
      walk_q      <= walk_d;
      used_q      <= used_d;
      cnt_q       <= cnt_d;
      loading_q   <= loading_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < Letters; i++) begin
        if (c_we && (c_waddr == 5'(i))) begin
          cipher_q[i] <= c_wdata;
        end
        if (i_we && (i_waddr == 5'(i))) begin
          inverse_q[i] <= i_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
  end

  assign empty      = !out_valid_q;
  assign out_byte_o = out_byte_q;

endmodule

>>> rtl/keyword_substitution_cipher.sv
// ----------------------------------------------------------------------------
// keyword_substitution_cipher: keyword monoalphabetic substitution cipher
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------
//   input    | push / full            | command_i, data_i, last_key_i
//   result   | empty / pop            | out_byte_o
//   config   | direction_we_i         | direction_i
//
// A text byte leaves the queue once the output register is free, a key character
// whenever the sequencer is idle; after the final key character the sequencer
// completes the alphabet and then builds the inverse table before it takes another item.
// Results wait in one output register while the input queue keeps filling.
// Reset loads the reversed alphabet into both tables and empties the queue.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher import ksc_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       command_i,
  input  logic [7:0] data_i,
  input  logic       last_key_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  input  logic       direction_we_i,
  input  logic       direction_i
);

  logic      direction_q;
  logic      head_valid;
  ksc_item_t head;
  logic      head_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= 1'b0;
    end else if (direction_we_i) begin
      direction_q <= direction_i;
    end
  end

  ksc_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .command_i    (command_i),
    .data_i       (data_i),
    .last_key_i   (last_key_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .head_pop_i   (head_pop)
  );

  ksc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .direction_i  (direction_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte_o)
  );

`ifndef NO_ASSERTIONS
  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop |-> head_valid)
    else $error("back end took an item from an empty queue");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full && !head_pop |=> full)
    else $error("queue lost an item without a pop");

  a_text_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop && head.text |=> !empty)
    else $error("text item produced no result");
`endif

endmodule

>>> tb/keyword_substitution_cipher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyword_substitution_cipher_tb: self-checking bench of the keyword cipher
// Drives key and text items through the push/full queue. A predictor builds
// both cipher tables from the accepted keys and predicts every text byte.
// Results are popped with random stalls and compared in order. The direction
// register is changed only when the block has drained.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher_tb;
  import ksc_pkg::*;

  localparam logic CmdKey     = 1'b0;
  localparam logic CmdText    = 1'b1;
  localparam logic DirEncrypt = 1'b0;
  localparam logic DirDecrypt = 1'b1;
  localparam int   DrainCycles = 200;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
    logic       last;
  } cipher_char_t;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       push           = 1'b0;
  logic       full;
  logic       command_i      = CmdKey;
  logic [7:0] data_i         = 8'h00;
  logic       last_key_i     = 1'b0;
  logic       empty;
  logic       pop            = 1'b0;
  logic [7:0] out_byte_o;
  logic       direction_we_i = 1'b0;
  logic       direction_i    = DirEncrypt;

  cipher_char_t pending_chars[$];
  logic [7:0]   predicted_bytes[$];
  int           error_count     = 0;
  int           sender_idle_pct = 0;
  int           recv_stall_pct  = 0;

  // predictor state
  logic [4:0]  enc_tab [Letters];
  logic [4:0]  dec_tab [Letters];
  logic [25:0] used_mask;
  int          placed;
  logic        key_open;
  logic        dir_sel;

  keyword_substitution_cipher dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .command_i      (command_i),
    .data_i         (data_i),
    .last_key_i     (last_key_i),
    .empty          (empty),
    .pop            (pop),
    .out_byte_o     (out_byte_o),
    .direction_we_i (direction_we_i),
    .direction_i    (direction_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [4:0] table_entry(input logic [4:0] idx);
    return dir_sel ? dec_tab[idx] : enc_tab[idx];
  endfunction

  task automatic cipher_apply(input cipher_char_t c);
    logic [7:0] up;
    logic [4:0] letter;
    logic [7:0] result;
    int n;
    if (c.cmd == CmdKey) begin
      if (!key_open) begin
        used_mask = '0;
        placed    = 0;
        key_open  = 1'b1;
      end
      up = c.data;
      if (up >= CharLowA && up <= CharLowZ) up = up - CaseGap;
      if (up >= CharUpA && up <= CharUpZ) begin
        letter = 5'(up - CharUpA);
        if (!used_mask[letter] && placed < Letters) begin
          enc_tab[placed]   = letter;
          used_mask[letter] = 1'b1;
          placed++;
        end
      end
      if (c.last) begin
        // fill the rest of the alphabet from Z down, then invert
        n = placed;
        for (int i = Letters; i > 0; i--) begin
          if (!used_mask[i-1] && n < Letters) begin
            enc_tab[n]     = 5'(i - 1);
            used_mask[i-1] = 1'b1;
            n++;
          end
        end
        placed = n;
        for (int i = 0; i < Letters; i++) dec_tab[enc_tab[i]] = 5'(i);
        key_open = 1'b0;
      end
    end else begin
      result = c.data;
      if (c.data >= CharUpA && c.data <= CharUpZ)
        result = 8'(table_entry(5'(c.data - CharUpA))) + CharLowA;
      else if (c.data >= CharLowA && c.data <= CharLowZ)
        result = 8'(table_entry(5'(c.data - CharLowA))) + CharUpA;
      predicted_bytes.push_back(result);
    end
  endtask

  // driver: hold the presented item until it is taken
  always @(posedge clk_i) begin : drive_chars
    logic hold;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      hold = push && full;
      if (push && !full) begin
        cipher_apply(pending_chars[0]);
        void'(pending_chars.pop_front());
      end
      if (!hold) begin
        if (pending_chars.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          push       <= 1'b1;
          command_i  <= pending_chars[0].cmd;
          data_i     <= pending_chars[0].data;
          last_key_i <= pending_chars[0].last;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each popped byte with the oldest prediction
  always @(posedge clk_i) begin : check_bytes
    logic [7:0] want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (predicted_bytes.size() == 0) begin
          $display("%0t: out_byte expected none, actual %02h", $time, out_byte_o);
          error_count++;
        end else begin
          want = predicted_bytes.pop_front();
          if (out_byte_o !== want) begin
            $display("%0t: out_byte expected %02h, actual %02h", $time, want, out_byte_o);
            error_count++;
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) ? CharLowA : CharUpA) + 8'($urandom_range(0, 25));
  endfunction

  task automatic queue_char(input logic cmd, input logic [7:0] data, input logic last);
    cipher_char_t c;
    c.cmd  = cmd;
    c.data = data;
    c.last = last;
    pending_chars.push_back(c);
  endtask

  // key of len characters, mostly letters; close it on the final one if asked
  task automatic queue_key(input int len, input logic finish);
    logic [7:0] ch;
    for (int i = 0; i < len; i++) begin
      ch = ($urandom_range(0, 99) < 85) ? rand_letter() : 8'($urandom_range(0, 255));
      queue_char(CmdKey, ch, finish && (i == len - 1));
    end
  endtask

  task automatic queue_text(input int len);
    logic [7:0] ch;
    for (int i = 0; i < len; i++) begin
      ch = ($urandom_range(0, 99) < 80) ? rand_letter() : 8'($urandom_range(0, 255));
      queue_char(CmdText, ch, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic drain();
    while (pending_chars.size() != 0 || predicted_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_direction(input logic dir);
    @(posedge clk_i);
    direction_we_i <= 1'b1;
    direction_i    <= dir;
    dir_sel = dir;
    @(posedge clk_i);
    direction_we_i <= 1'b0;
  endtask

  task automatic run_random_phase(input logic dir, input int sidle, input int rstall,
                                  input int nitems);
    int start;
    int kind;
    int len;
    drain();
    write_direction(dir);
    sender_idle_pct = sidle;
    recv_stall_pct  = rstall;
    start = pending_chars.size();
    for (int n = 0; n < nitems; n = n + 0) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(26, 34) : $urandom_range(1, 10);
        queue_key(len, 1'b1);
        queue_text($urandom_range(4, 12));
      end else if (kind == 6) begin
        // text while a key is still open, then close it
        queue_key($urandom_range(1, 5), 1'b0);
        queue_text($urandom_range(1, 4));
        queue_key($urandom_range(1, 5), 1'b1);
        queue_text($urandom_range(1, 4));
      end else begin
        queue_char(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   ($urandom_range(0, 3) == 0));
      end
      n = pending_chars.size() - start;
      // the driver may already have taken some items
      if (n < 0) n = 0;
      start = start;
      if (pending_chars.size() == 0) break;
      nitems = nitems;
      if (n >= nitems) break;
      n = 0;
      nitems = nitems - (pending_chars.size() - start);
      start = pending_chars.size();
    end
  endtask

  initial begin
    for (int i = 0; i < Letters; i++) begin
      enc_tab[i] = 5'(25 - i);
      dec_tab[i] = 5'(25 - i);
    end
    used_mask = '0;
    placed    = 0;
    key_open  = 1'b0;
    dir_sel   = DirEncrypt;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_direction(DirEncrypt);
    // reset tables: letter edges, case edges and non-letters
    queue_char(CmdText, CharUpA, 1'b0);
    queue_char(CmdText, CharUpZ, 1'b1);
    queue_char(CmdText, CharLowA, 1'b0);
    queue_char(CmdText, CharLowZ, 1'b0);
    queue_char(CmdText, 8'h00, 1'b0);
    queue_char(CmdText, 8'hFF, 1'b1);
    queue_char(CmdText, 8'h40, 1'b0);
    queue_char(CmdText, 8'h5B, 1'b0);
    queue_char(CmdText, 8'h60, 1'b0);
    queue_char(CmdText, 8'h7B, 1'b0);
    // empty key: only a non-letter closes it
    queue_char(CmdKey, 8'h20, 1'b1);
    queue_char(CmdText, 8'h4D, 1'b0);
    // repeats after case folding, non-letters inside the key
    queue_char(CmdKey, 8'h7A, 1'b0);
    queue_char(CmdKey, 8'h45, 1'b0);
    queue_char(CmdKey, 8'h31, 1'b0);
    queue_char(CmdKey, 8'h5A, 1'b0);
    queue_char(CmdKey, 8'h62, 1'b0);
    // text while the key is open
    queue_char(CmdText, CharUpA, 1'b0);
    queue_char(CmdText, 8'h65, 1'b0);
    queue_char(CmdKey, 8'h65, 1'b0);
    queue_char(CmdKey, 8'hFF, 1'b1);
    queue_char(CmdText, CharUpA, 1'b0);
    queue_char(CmdText, CharLowZ, 1'b0);
    queue_char(CmdText, 8'h42, 1'b0);
    queue_char(CmdText, 8'h21, 1'b0);

    run_random_phase(DirEncrypt, 0, 0, 75);
    run_random_phase(DirDecrypt, 79, 0, 75);
    run_random_phase(DirDecrypt, 0, 79, 75);
    run_random_phase(DirEncrypt, 35, 35, 75);
    run_random_phase(DirDecrypt, 0, 0, 75);
    run_random_phase(DirEncrypt, 79, 0, 75);
    run_random_phase(DirEncrypt, 0, 79, 75);
    run_random_phase(DirDecrypt, 35, 35, 75);
    drain();

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
